// ===== src/cbsnf_pkg.sv =====
// cbsnf_pkg: shared sizes, register indexes and word types for the checkerboard split block
// no dependencies; imported by every module of the block
package cbsnf_pkg;

	// line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// configuration port
	localparam int DIM_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(1000);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(1000);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// one line store column: two rows back and one row back
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		line_t            data;
	} line_wr_t;

	// everything the fill logic needs for one output position
	typedef struct packed {
		pix_t self_pix;
		pix_t up;
		pix_t down;
		pix_t left;
		pix_t right;
		logic has_up;
		logic has_down;
		logic has_left;
		logic has_right;
		logic first_owns;
		logic frame_end;
	} nbr_t;

	typedef struct packed {
		pix_t first;
		pix_t second;
		logic frame_end;
	} res_t;

endpackage

// ===== src/cbsnf_line_store.sv =====
// cbsnf_line_store: column store of the two previous rows, one write and two registered reads
// depends on cbsnf_pkg for geometry and word types
module cbsnf_line_store (
	input  logic                       clk,
	input  cbsnf_pkg::line_wr_t        wr,
	input  logic [cbsnf_pkg::COL_W-1:0] raddr_a,
	input  logic [cbsnf_pkg::COL_W-1:0] raddr_b,
	output cbsnf_pkg::line_t           rdata_a,
	output cbsnf_pkg::line_t           rdata_b
);
	import cbsnf_pkg::*;

	line_t mem [MAX_WIDTH];
	line_t rd_a_q;
	line_t rd_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read ports, new data forwarded on a same-address write
	always_ff @(posedge clk) begin
		if (wr.en && wr.addr == raddr_a) begin
			rd_a_q <= wr.data;
		end else begin
			rd_a_q <= mem[raddr_a];
		end
		if (wr.en && wr.addr == raddr_b) begin
			rd_b_q <= wr.data;
		end else begin
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== src/cbsnf_fill.sv =====
// cbsnf_fill: per-channel neighbour average and image one / image two selection
// depends on cbsnf_pkg for the neighbour and result words
module cbsnf_fill (
	input  cbsnf_pkg::nbr_t nbr,
	output cbsnf_pkg::res_t res
);
	import cbsnf_pkg::*;

	// 683 / 2048 gives an exact floor of x / 3 for x below 2048
	localparam logic [19:0] RECIP3 = 20'd683;

	function automatic logic [7:0] chan_avg(
		input logic [7:0] u,
		input logic [7:0] d,
		input logic [7:0] l,
		input logic [7:0] r,
		input logic [3:0] has
	);
		logic [9:0]  sum;
		logic [2:0]  n;
		logic [19:0] prod;
		sum  = (has[3] ? {2'b00, u} : 10'd0) + (has[2] ? {2'b00, d} : 10'd0)
		     + (has[1] ? {2'b00, l} : 10'd0) + (has[0] ? {2'b00, r} : 10'd0);
		n    = 3'(has[3]) + 3'(has[2]) + 3'(has[1]) + 3'(has[0]);
		prod = 20'(sum) * RECIP3;
		case (n)
			3'd2:    return sum[8:1];
			3'd3:    return prod[18:11];
			3'd4:    return sum[9:2];
			default: return 8'd0;
		endcase
	endfunction

	logic [3:0] has;
	pix_t       fill;

	assign has = {nbr.has_up, nbr.has_down, nbr.has_left, nbr.has_right};

	// average of the neighbours that exist
	always_comb begin
		fill.red   = chan_avg(nbr.up.red, nbr.down.red, nbr.left.red, nbr.right.red, has);
		fill.green = chan_avg(nbr.up.green, nbr.down.green, nbr.left.green,
		                      nbr.right.green, has);
		fill.blue  = chan_avg(nbr.up.blue, nbr.down.blue, nbr.left.blue, nbr.right.blue, has);
	end

	// owning image takes the pixel as it arrived
	always_comb begin
		res.first     = nbr.first_owns ? nbr.self_pix : fill;
		res.second    = nbr.first_owns ? fill : nbr.self_pix;
		res.frame_end = nbr.frame_end;
	end

endmodule

// ===== src/cbsnf_out_fifo.sv =====
// cbsnf_out_fifo: two-word result queue between the fill logic and the result channel
// depends on cbsnf_pkg for the result word
module cbsnf_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cbsnf_pkg::res_t din,
	output logic            full,
	output logic            res_valid,
	input  logic            res_ready,
	output cbsnf_pkg::res_t dout
);
	import cbsnf_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = res_valid && res_ready;
	assign res_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign dout      = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== src/checkerboard_split_neighbour_fill_top.sv =====
// checkerboard_split_neighbour_fill_top: raster position control, line store and result queue
// depends on cbsnf_pkg, cbsnf_line_store, cbsnf_fill and cbsnf_out_fifo
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   pix     | pix_valid / pix_ready | mode, red, green, blue
//   res     | res_valid / res_ready | first_*, second_* (red, green, blue), frame_end
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word accepted per cycle while pix_ready is high; a result is written into the output queue
// when its word is taken. both columns a word needs are read in the cycle before, at the column
// the position counter will point to next, so the line store never holds up the input.
// pix_ready drops while two results wait in the output queue or a register write is offered;
// cfg_ready is always high.
// reset clears the position counters and loads width and height of 1000; the line store
// is not cleared, every entry is written before its value is used.
module checkerboard_split_neighbour_fill_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_ready,
	input  logic                            mode,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [7:0]                      first_red,
	output logic [7:0]                      first_green,
	output logic [7:0]                      first_blue,
	output logic [7:0]                      second_red,
	output logic [7:0]                      second_green,
	output logic [7:0]                      second_blue,
	output logic                            frame_end,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbsnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbsnf_pkg::DIM_W-1:0]     cfg_data
);
	import cbsnf_pkg::*;

	// last column in use, width clamped to 2 .. MAX_WIDTH
	function automatic logic [COL_W-1:0] last_col_of(input logic [DIM_W-1:0] w);
		if (w < DIM_W'(2)) begin
			return COL_W'(1);
		end else if (32'(w) > MAX_WIDTH) begin
			return COL_W'(MAX_WIDTH - 1);
		end else begin
			return COL_W'(w - DIM_W'(1));
		end
	endfunction

	logic [COL_W-1:0] wlast_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] in_row_q;
	logic [COL_W-1:0] in_col_q;
	pix_t             left_q;

	logic             cfg_wr;
	logic             cfg_hit;
	logic             accept;
	logic             draining;
	logic             do_pixel;
	logic             do_drain;
	logic             at_last;
	logic [DIM_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;
	pix_t             pix_in;
	line_t            cur;
	line_t            ahead;
	line_wr_t         wr;
	nbr_t             nbr;
	res_t             res_new;
	res_t             res_out;
	logic             push;
	logic             full;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
	assign pix_ready = !full && !cfg_valid;
	assign accept    = pix_valid && pix_ready;

	assign pix_in   = '{red: red, green: green, blue: blue};
	assign draining = (in_row_q >= height_q);
	assign do_pixel = accept && !draining && !mode;
	assign do_drain = accept && draining && mode;
	assign at_last  = (in_col_q == wlast_q);

	// next raster position
	always_comb begin
		nxt_row = in_row_q;
		nxt_col = in_col_q;
		if (cfg_hit) begin
			nxt_row = '0;
			nxt_col = '0;
		end else if (do_pixel || do_drain) begin
			if (at_last) begin
				nxt_col = '0;
				nxt_row = do_pixel ? in_row_q + DIM_W'(1) : '0;
			end else begin
				nxt_col = in_col_q + COL_W'(1);
			end
		end
	end

	// configuration and position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q  <= last_col_of(RST_WIDTH);
			height_q <= RST_HEIGHT;
			in_row_q <= '0;
			in_col_q <= '0;
		end else begin
			if (cfg_wr && cfg_index == REG_WIDTH) begin
				wlast_q <= last_col_of(cfg_data);
			end
			if (cfg_wr && cfg_index == REG_HEIGHT) begin
				height_q <= (cfg_data < DIM_W'(2)) ? DIM_W'(2) : cfg_data;
			end
			in_row_q <= nxt_row;
			in_col_q <= nxt_col;
		end
	end

	// previous row's pixel one column to the left
	always_ff @(posedge clk) begin
		if (do_pixel || do_drain) begin
			left_q <= cur.middle;
		end
	end

	// line store: pixel shifts the column up a row, drain copies the middle row up
	always_comb begin
		wr.en          = do_pixel || do_drain;
		wr.addr        = in_col_q;
		wr.data.upper  = cur.middle;
		wr.data.middle = do_pixel ? pix_in : cur.middle;
	end

	cbsnf_line_store u_line (
		.clk     (clk),
		.wr      (wr),
		.raddr_a (nxt_col),
		.raddr_b (nxt_col + COL_W'(1)),
		.rdata_a (cur),
		.rdata_b (ahead)
	);

	// neighbours of the position one row behind the input
	always_comb begin
		nbr.self_pix   = cur.middle;
		nbr.up         = cur.upper;
		nbr.down       = pix_in;
		nbr.left       = left_q;
		nbr.right      = ahead.middle;
		nbr.has_up     = do_drain || (in_row_q >= DIM_W'(2));
		nbr.has_down   = !do_drain;
		nbr.has_left   = (in_col_q != '0);
		nbr.has_right  = !at_last;
		nbr.first_owns = (do_drain ? ~height_q[0] : ~in_row_q[0]) == in_col_q[0];
		nbr.frame_end  = do_drain && at_last;
	end

	cbsnf_fill u_fill (
		.nbr (nbr),
		.res (res_new)
	);

	assign push = do_drain || (do_pixel && in_row_q != '0);

	cbsnf_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res_new),
		.full      (full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.dout      (res_out)
	);

	assign first_red    = res_out.first.red;
	assign first_green  = res_out.first.green;
	assign first_blue   = res_out.first.blue;
	assign second_red   = res_out.second.red;
	assign second_green = res_out.second.green;
	assign second_blue  = res_out.second.blue;
	assign frame_end    = res_out.frame_end;

endmodule

// ===== src/cbsnf_checker.sv =====
// cbsnf_checker: port-level properties of the checkerboard split block, bound to the top level
// depends on cbsnf_pkg and checkerboard_split_neighbour_fill_top
module cbsnf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pix_valid,
	input logic                            pix_ready,
	input logic                            mode,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [7:0]                      first_red,
	input logic [7:0]                      first_green,
	input logic [7:0]                      first_blue,
	input logic [7:0]                      second_red,
	input logic [7:0]                      second_green,
	input logic [7:0]                      second_blue,
	input logic                            frame_end,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [cbsnf_pkg::CFG_IDX_W-1:0] cfg_index
);
	import cbsnf_pkg::*;

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result word does not change
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(first_red) && $stable(first_green)
			&& $stable(first_blue) && $stable(second_red) && $stable(second_green)
			&& $stable(second_blue) && $stable(frame_end))
		else $error("result word changed while stalled");

	// input backpressure only while a result is waiting or a register write is offered
	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready && !cfg_valid |-> res_valid)
		else $error("pixel channel stalled with no result waiting");

	// a register write restarts the frame, so the first pixel word gives no result
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)
			&& !res_valid)
		##1 (pix_valid && pix_ready && !mode && !cfg_valid) |=> !res_valid)
		else $error("result produced for first row after register write");

endmodule

bind checkerboard_split_neighbour_fill_top cbsnf_checker u_cbsnf_checker (.*);

// ===== tb/checkerboard_split_neighbour_fill_top_tb.sv =====
// checkerboard_split_neighbour_fill_top_tb: self-checking bench for the checkerboard split block
// depends on cbsnf_pkg and checkerboard_split_neighbour_fill_top; a directed table, then random
// frames, every result checked against a typed pair or an in-bench predictor of split and fill
`timescale 1ns / 1ps

module checkerboard_split_neighbour_fill_top_tb;

	import cbsnf_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          RANDOM_WORDS  = 1000;
	localparam int          LATE_WORDS    = 750;
	localparam int          DIR_ROWS      = 28;
	localparam int          PRINT_CAP     = 100;

	localparam logic        MODE_PIXEL    = 1'b0;
	localparam logic        MODE_DRAIN    = 1'b1;

	// indexes past the two registers, writes there change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	localparam pix_t PIX_WHITE       = 24'hffffff;
	localparam pix_t PIX_BLACK       = 24'h000000;
	localparam res_t NO_PAIR         = '0;
	localparam res_t WHITE_BLACK     = {24'hffffff, 24'h000000, 1'b0};
	localparam res_t WHITE_BLACK_END = {24'hffffff, 24'h000000, 1'b1};

	// how the expectation of a directed word is obtained
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_TYPED
	} word_check_e;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [DIM_W-1:0]     dim;
		logic                 mode;
		pix_t                 pix;
		word_check_e          chk;
		res_t                 typed;
	} step_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 pix_valid   = 1'b0;
	logic                 pix_ready;
	logic                 mode        = MODE_PIXEL;
	logic [7:0]           red         = '0;
	logic [7:0]           green       = '0;
	logic [7:0]           blue        = '0;
	logic                 res_valid;
	logic                 res_ready   = 1'b0;
	logic [7:0]           first_red;
	logic [7:0]           first_green;
	logic [7:0]           first_blue;
	logic [7:0]           second_red;
	logic [7:0]           second_green;
	logic [7:0]           second_blue;
	logic                 frame_end;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_WIDTH;
	logic [DIM_W-1:0]     cfg_data    = '0;

	// travels with each word so the monitor knows how to check it
	word_check_e          word_check  = CHK_PREDICT;
	res_t                 word_typed  = '0;

	logic                 late        = 1'b0;
	logic                 calm        = 1'b0;
	wire                  quiet       = late | calm;

	// predictor state
	pix_t                 line_up  [MAX_WIDTH];
	pix_t                 line_mid [MAX_WIDTH];
	logic [DIM_W-1:0]     dim_w       = RST_WIDTH;
	logic [DIM_W-1:0]     dim_h       = RST_HEIGHT;
	int                   in_r        = 0;
	int                   in_c        = 0;

	res_t                 image_pairs [$];
	res_t                 pred_pair;
	res_t                 due_pair;
	logic                 pred_hit;
	int                   mismatches  = 0;
	int unsigned          cycle_count = 0;
	int                   stall_left  = 0;
	int                   frame_words = 0;
	step_t                dir_tab [DIR_ROWS];

	checkerboard_split_neighbour_fill_top i_dut (.*);

	always #4 clk = ~clk;

	function automatic int used_cols(input int dim);
		return dim < 2 ? 2 : (dim > MAX_WIDTH ? MAX_WIDTH : dim);
	endfunction

	function automatic int used_rows(input int dim);
		return dim < 2 ? 2 : dim;
	endfunction

	// truncated mean of the neighbours present, order up, down, left, right
	function automatic logic [7:0] neighbour_mean(input logic [7:0] u, input logic [7:0] d,
			input logic [7:0] l, input logic [7:0] r, input logic [3:0] has);
		int s;
		int n;
		s = 0;
		n = 0;
		if (has[3]) begin s += u; n++; end
		if (has[2]) begin s += d; n++; end
		if (has[1]) begin s += l; n++; end
		if (has[0]) begin s += r; n++; end
		return n == 0 ? 8'h00 : 8'(s / n);
	endfunction

	// owner keeps its pixel, the other image takes the neighbour fill
	function automatic res_t pair_at(input int parity, input pix_t own, input pix_t up,
			input logic hu, input pix_t dn, input logic hd, input pix_t lf, input logic hl,
			input pix_t rt, input logic hr, input logic last);
		logic [3:0] has;
		pix_t       fill;
		res_t       r;
		has = {hu, hd, hl, hr};
		fill.red   = neighbour_mean(up.red, dn.red, lf.red, rt.red, has);
		fill.green = neighbour_mean(up.green, dn.green, lf.green, rt.green, has);
		fill.blue  = neighbour_mean(up.blue, dn.blue, lf.blue, rt.blue, has);
		r.frame_end = last;
		if (parity % 2 == 0) begin
			r.first  = own;
			r.second = fill;
		end else begin
			r.first  = fill;
			r.second = own;
		end
		return r;
	endfunction

	// advance the raster position by one word, return 1 when a pair is emitted
	function automatic logic split_pixel(input logic m, input pix_t p, output res_t r);
		int   w;
		int   h;
		int   c;
		pix_t lf;
		pix_t rt;
		logic hit;
		w = used_cols(dim_w);
		h = used_rows(dim_h);
		hit = 1'b0;
		r = NO_PAIR;
		if (in_c >= w)
			in_c = 0;
		c = in_c;
		lf = c > 0 ? line_up[c - 1] : PIX_BLACK;
		rt = c + 1 < w ? line_mid[c + 1] : PIX_BLACK;
		if (in_r < h && m == MODE_PIXEL) begin
			// row zero only fills the line store
			if (in_r >= 1) begin
				r = pair_at(in_r - 1 + c, line_mid[c], line_up[c], in_r >= 2, p, 1'b1,
					lf, c > 0, rt, c + 1 < w, 1'b0);
				hit = 1'b1;
			end
			line_up[c]  = line_mid[c];
			line_mid[c] = p;
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r++;
			end
		end else if (in_r >= h && m == MODE_DRAIN) begin
			// last row has no neighbour below
			r = pair_at(h - 1 + c, line_mid[c], line_up[c], 1'b1, PIX_BLACK, 1'b0,
				lf, c > 0, rt, c + 1 < w, c + 1 == w);
			hit = 1'b1;
			line_up[c] = line_mid[c];
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r = 0;
			end
		end
		return hit;
	endfunction

	// register write restarts the frame, spare indexes do nothing
	function automatic void set_dimension(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] dim);
		if (idx == REG_WIDTH)
			dim_w = dim;
		else if (idx == REG_HEIGHT)
			dim_h = dim;
		else
			return;
		in_r = 0;
		in_c = 0;
	endfunction

	function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [DIM_W-1:0] dim);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.dim    = dim;
		return s;
	endfunction

	function automatic step_t word_row(input logic m, input pix_t p, input word_check_e k,
			input res_t t);
		step_t s;
		s = '0;
		s.mode  = m;
		s.pix   = p;
		s.chk   = k;
		s.typed = t;
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		// keep the log short when the block is badly off
		if (mismatches < PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// present one word, with an occasional gap before it
	task automatic send_word(input logic m, input pix_t p, input word_check_e k, input res_t t);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid  <= 1'b1;
		mode       <= m;
		red        <= p.red;
		green      <= p.green;
		blue       <= p.blue;
		word_check <= k;
		word_typed <= t;
		do @(posedge clk); while (!(pix_valid && pix_ready));
	endtask

	// registers change only once the block has gone quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] dim);
		pix_valid <= 1'b0;
		while (image_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= dim;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	// well-formed frame (pixels then drains), cut short when cut < full length
	task automatic stream_frame(input int cols, input int rows, input int cut);
		int   k;
		logic m;
		for (k = 0; k < cut; k++) begin
			m = k < cols * rows ? MODE_PIXEL : MODE_DRAIN;
			// a word of the other mode is ignored in this phase
			if (!late && $urandom_range(0, 19) == 0)
				send_word(~m, pix_t'(24'($urandom)), CHK_PREDICT, NO_PAIR);
			send_word(m, pix_t'(24'($urandom)), CHK_PREDICT, NO_PAIR);
			frame_words++;
		end
	endtask

	// result side stalls in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			if (stall_left == 0)
				res_ready <= 1'b1;
		end else if (arst_n && !quiet && $urandom_range(0, 5) == 0) begin
			res_ready <= 1'b0;
			stall_left = $urandom_range(1, 11);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// predict on accepted words, check accepted results, watch the clock
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				set_dimension(cfg_index, cfg_data);
			if (pix_valid && pix_ready) begin
				pred_hit = split_pixel(mode, {red, green, blue}, pred_pair);
				case (word_check)
					CHK_PREDICT: begin
						if (pred_hit)
							image_pairs.push_back(pred_pair);
					end
					CHK_TYPED: image_pairs.push_back(word_typed);
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (image_pairs.size() == 0) begin
					report_mismatch("result with nothing pending");
				end else begin
					due_pair = image_pairs.pop_front();
					cmp_field("first_red", first_red, due_pair.first.red);
					cmp_field("first_green", first_green, due_pair.first.green);
					cmp_field("first_blue", first_blue, due_pair.first.blue);
					cmp_field("second_red", second_red, due_pair.second.red);
					cmp_field("second_green", second_green, due_pair.second.green);
					cmp_field("second_blue", second_blue, due_pair.second.blue);
					cmp_field("frame_end", 8'(frame_end), 8'(due_pair.frame_end));
				end
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int   i;
		int   fw;
		int   fh;
		int   wu;
		int   hu;
		int   total;
		int   cut;
		logic need_cfg;

		// directed: reset sizes, clamped 2x2 frame, ignored words, restarts, truncation
		dir_tab = '{
			word_row(MODE_PIXEL, PIX_WHITE, CHK_NONE, NO_PAIR),
			word_row(MODE_DRAIN, PIX_BLACK, CHK_NONE, NO_PAIR),
			cfg_row(REG_WIDTH, DIM_W'(1)),
			cfg_row(REG_HEIGHT, DIM_W'(0)),
			word_row(MODE_PIXEL, PIX_WHITE, CHK_NONE, NO_PAIR),
			word_row(MODE_PIXEL, PIX_BLACK, CHK_NONE, NO_PAIR),
			cfg_row(REG_SPARE_A, DIM_W'(2047)),
			word_row(MODE_PIXEL, PIX_BLACK, CHK_TYPED, WHITE_BLACK),
			word_row(MODE_DRAIN, PIX_WHITE, CHK_NONE, NO_PAIR),
			word_row(MODE_PIXEL, PIX_WHITE, CHK_TYPED, WHITE_BLACK),
			word_row(MODE_PIXEL, 24'h5a5a5a, CHK_NONE, NO_PAIR),
			word_row(MODE_DRAIN, PIX_BLACK, CHK_TYPED, WHITE_BLACK),
			word_row(MODE_DRAIN, PIX_BLACK, CHK_TYPED, WHITE_BLACK_END),
			word_row(MODE_PIXEL, 24'h123456, CHK_NONE, NO_PAIR),
			cfg_row(REG_SPARE_B, DIM_W'(0)),
			cfg_row(REG_WIDTH, DIM_W'(3)),
			word_row(MODE_PIXEL, 24'h010203, CHK_PREDICT, NO_PAIR),
			word_row(MODE_PIXEL, 24'hfefdfc, CHK_PREDICT, NO_PAIR),
			cfg_row(REG_HEIGHT, DIM_W'(2)),
			word_row(MODE_PIXEL, 24'hff0001, CHK_PREDICT, NO_PAIR),
			word_row(MODE_PIXEL, 24'h00ff02, CHK_PREDICT, NO_PAIR),
			word_row(MODE_PIXEL, 24'h0300ff, CHK_PREDICT, NO_PAIR),
			word_row(MODE_PIXEL, 24'h7f8081, CHK_PREDICT, NO_PAIR),
			word_row(MODE_PIXEL, 24'h010101, CHK_PREDICT, NO_PAIR),
			word_row(MODE_PIXEL, 24'hfefefe, CHK_PREDICT, NO_PAIR),
			word_row(MODE_DRAIN, PIX_BLACK, CHK_PREDICT, NO_PAIR),
			word_row(MODE_DRAIN, PIX_WHITE, CHK_PREDICT, NO_PAIR),
			word_row(MODE_DRAIN, PIX_BLACK, CHK_PREDICT, NO_PAIR)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].is_cfg)
				write_reg(dir_tab[i].idx, dir_tab[i].dim);
			else
				send_word(dir_tab[i].mode, dir_tab[i].pix, dir_tab[i].chk, dir_tab[i].typed);
		end

		// random frames, mostly small, some cut short, some back to back; no idling at the end
		need_cfg = 1'b1;
		fw = 2;
		fh = 2;
		while (frame_words < RANDOM_WORDS) begin
			late = frame_words >= LATE_WORDS;
			calm = !late && $urandom_range(0, 3) == 0;
			if (need_cfg || $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: fw = $urandom_range(0, 1);
					1: fw = $urandom_range(13, 64);
					default: fw = $urandom_range(2, 12);
				endcase
				case ($urandom_range(0, 9))
					0: fh = $urandom_range(0, 1);
					1: fh = $urandom_range(7, 12);
					default: fh = $urandom_range(2, 6);
				endcase
				if ($urandom_range(0, 7) == 0)
					write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
						DIM_W'($urandom_range(0, 2047)));
				write_reg(REG_WIDTH, DIM_W'(fw));
				write_reg(REG_HEIGHT, DIM_W'(fh));
			end
			wu = used_cols(fw);
			hu = used_rows(fh);
			total = wu * hu + wu;
			cut = $urandom_range(0, 9) == 0 ? $urandom_range(1, total - 1) : total;
			stream_frame(wu, hu, cut);
			need_cfg = cut != total;
		end

		// drain what is still pending
		pix_valid <= 1'b0;
		while (image_pairs.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
